/* design/mlps_pkg.sv */
// Package for the min_largest_partition_sum block: shared constants, item types,
// controller state encoding and the command and status bundles.
// Depends on nothing; mlps_ctrl, mlps_dp and the top module import it.
package mlps_pkg;

  localparam int ELEMENT_BITS    = 16;
  localparam int MAX_ELEMENTS    = 1024;
  localparam int PART_COUNT_BITS = 11;
  localparam int SUM_OUT_BITS    = 26;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0] element_value;
    logic                    last_element;
  } in_t;

  typedef struct packed {
    logic [SUM_OUT_BITS-1:0] largest_sum;
    logic                    no_solution;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_PASS,
    ST_DRAIN,
    ST_EVAL,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // store one accepted element
    logic start;   // open the search bounds
    logic setup;   // latch the probe and clear the pass accumulators
    logic rd_en;   // read the next stored element
    logic eval;    // narrow the bounds from the finished pass
    logic finish;  // hand the result over and clear the sequence
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_sol;      // part count is zero or above the element count
    logic last_addr;   // the read being issued is the last element
    logic search_end;  // the current evaluation closes the search
    logic out_free;    // the output register can take a result
  } status_t;

endpackage

/* design/mlps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mlps_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mlps_ctrl.sv */
// Controller state machine of the min_largest_partition_sum block.
// Depends on mlps_pkg for the state encoding and the command and status bundles.
module mlps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  mlps_pkg::status_t status_i,
  output mlps_pkg::cmd_t    cmd_o
);
  import mlps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.no_sol ? ST_DONE : ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_PASS;
      end
      ST_PASS: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.search_end ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mlps_dp.sv */
// Datapath of the min_largest_partition_sum block: element store, running sums,
// search bounds, greedy pass accumulators and the output register.
// Depends on mlps_pkg and mlps_ram.
module mlps_dp #(
  parameter int MaxElements = mlps_pkg::MAX_ELEMENTS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic [mlps_pkg::PART_COUNT_BITS-1:0]    cfg_data_i,
  input  logic [mlps_pkg::ELEMENT_BITS-1:0]       elem_i,
  input  mlps_pkg::cmd_t                          cmd_i,
  output mlps_pkg::status_t                       status_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output mlps_pkg::out_t                          out_data_o
);
  import mlps_pkg::*;

  localparam int AddrW = $clog2(MaxElements);
  localparam int CntW  = $clog2(MaxElements + 1);
  localparam int SumW  = ELEMENT_BITS + CntW;
  localparam int CmpW  = (CntW > PART_COUNT_BITS) ? CntW : PART_COUNT_BITS;

  logic [PART_COUNT_BITS-1:0] part_count_q;
  logic [CntW-1:0]            count_q;
  logic [ELEMENT_BITS-1:0]    max_q;
  logic [SumW-1:0]            total_q;
  logic [SumW-1:0]            low_q, high_q, mid_q, part_sum_q;
  logic [CntW-1:0]            tally_q;
  logic [AddrW-1:0]           addr_q;
  logic                       rd_vld_q;
  logic                       nosol_q;
  logic                       out_valid_q;
  out_t                       out_q;

  logic                    store_we;
  logic [ELEMENT_BITS-1:0] rdata;
  logic [SumW:0]           bound_sum;
  logic [SumW:0]           trial_sum;
  logic                    feasible;

  assign store_we = cmd_i.load && (count_q < CntW'(MaxElements));

  mlps_ram #(
    .Width(ELEMENT_BITS),
    .Depth(MaxElements)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(elem_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign bound_sum = {1'b0, low_q} + {1'b0, high_q};
  assign trial_sum = {1'b0, part_sum_q} + (SumW + 1)'(rdata);
  assign feasible  = CmpW'(tally_q) <= CmpW'(part_count_q);

  assign status_o.no_sol     = (part_count_q == '0) ||
                               (CmpW'(part_count_q) > CmpW'(count_q));
  assign status_o.last_addr  = (CntW'(addr_q) + CntW'(1)) == count_q;
  assign status_o.search_end = feasible ? (mid_q == low_q) : (mid_q == high_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= PART_COUNT_BITS'(1);
      count_q      <= '0;
      max_q        <= '0;
      total_q      <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        part_count_q <= cfg_data_i;
      end
      if (store_we) begin
        count_q <= count_q + CntW'(1);
        total_q <= total_q + SumW'(elem_i);
        if (elem_i > max_q) begin
          max_q <= elem_i;
        end
      end
      if (cmd_i.finish) begin
        count_q <= '0;
        max_q   <= '0;
        total_q <= '0;
      end
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search bounds, probe and pass accumulators carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      nosol_q <= status_o.no_sol;
      low_q   <= SumW'(max_q);
      high_q  <= total_q;
    end
    if (cmd_i.setup) begin
      mid_q      <= bound_sum[SumW:1];
      part_sum_q <= '0;
      tally_q    <= CntW'(1);
      addr_q     <= '0;
    end
    if (cmd_i.rd_en) begin
      addr_q <= addr_q + AddrW'(1);
    end
    if (rd_vld_q) begin
      if (trial_sum <= (SumW + 1)'(mid_q)) begin
        part_sum_q <= trial_sum[SumW-1:0];
      end else begin
        tally_q    <= tally_q + CntW'(1);
        part_sum_q <= SumW'(rdata);
      end
    end
    if (cmd_i.eval) begin
      if (feasible) begin
        high_q <= mid_q - SumW'(1);
      end else begin
        low_q <= mid_q + SumW'(1);
      end
    end
    if (cmd_i.finish) begin
      out_q.no_solution <= nosol_q;
      out_q.largest_sum <= nosol_q ? '0 : SUM_OUT_BITS'(low_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (CntW'(addr_q) < count_q))
    else $error("element read beyond the held sequence");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.setup |-> (low_q <= high_q))
    else $error("probe started with an empty search interval");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxElements))
    else $error("element count above store depth");

  a_nosol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (!out_q.no_solution || (out_q.largest_sum == '0)))
    else $error("no-solution result carries a nonzero sum");
`endif

endmodule

/* design/min_largest_partition_sum.sv */
// Elements load only while idle; a result waiting at the output does not block loading.
// After the last element of N, the block runs P binary-search probes, P being about
// log2(total - maximum + 1). Each probe is one greedy pass over the element store, one RAM
// read per cycle, which sets the rate. No-solution results skip the search entirely.
// Reset clears the control state, part_count returns to 1; store contents need no clearing.
module min_largest_partition_sum #(
  parameter int MaxElements = mlps_pkg::MAX_ELEMENTS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mlps_pkg::PART_COUNT_BITS-1:0] cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mlps_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mlps_pkg::out_t                       out_data_o
);
  import mlps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The part count register must only be written while the block is idle; the block
  // itself does not enforce this, so the user is bound by it. It is always ready.
  assign cfg_ready_o = 1'b1;

  // The controller accepts items only while no search is running. Each accepted item is
  // written to the element store while it has room; the one marked last starts the search.
  mlps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_data_i.last_element),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // The datapath holds the store, the running maximum and total, the search
  // bounds and the output register, which parts the result from the next sequence.
  mlps_dp #(
    .MaxElements(MaxElements)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .elem_i     (in_data_i.element_value),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* bench/min_largest_partition_sum_test.sv */
// Self-checking bench for min_largest_partition_sum: loads element sequences, predicts the
// smallest possible largest part sum for each one and compares every answer from the block.
// Depends on mlps_pkg and the min_largest_partition_sum RTL; nothing else is read.
module min_largest_partition_sum_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlps_pkg::*;

  // Generous bound: the slowest legal run is a small fraction of this.
  localparam int CycleLimit = 1_000_000;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [PART_COUNT_BITS-1:0] cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  in_t                        in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  out_t                       out_data_o;

  min_largest_partition_sum u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Items waiting to be offered, and answers the block still owes us.
  in_t  pending_items[$];
  out_t expected_answers[$];

  // Private copy of the block's state, as seen through its ports.
  logic [ELEMENT_BITS-1:0]    held_elements [MAX_ELEMENTS];
  logic [PART_COUNT_BITS-1:0] held_count   = '0;
  logic [ELEMENT_BITS-1:0]    held_max     = '0;
  logic [26:0]                held_total   = '0;
  logic [PART_COUNT_BITS-1:0] part_setting = 1;  // the register's reset value

  int idle_max         = 6;
  int send_wait        = 0;
  int recv_wait        = 0;
  int mismatches       = 0;
  int elements_sent    = 0;
  int answers_checked  = 0;
  int no_solution_seen = 0;
  int cycle_count      = 0;

  // Most draws are short, at least a quarter of them no wait at all; idle_max of zero turns
  // idling off completely for a stretch of the run.
  function automatic int draw_wait();
    if (idle_max == 0 || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, idle_max);
  endfunction

  // Takes one accepted element into the private state. On the last element of a
  // sequence it binary-searches the smallest feasible limit, exactly as the block is
  // meant to, queues the answer and forgets the sequence.
  function automatic void absorb_element(input in_t item);
    out_t answer;
    int   lo;
    int   hi;
    int   mid;
    int   run;
    int   tally;
    // A full store simply drops the element, but a last flag still closes the sequence.
    if (held_count < MAX_ELEMENTS) begin
      held_elements[held_count] = item.element_value;
      held_count++;
      if (item.element_value > held_max) begin
        held_max = item.element_value;
      end
      held_total += item.element_value;
    end
    if (!item.last_element) begin
      return;
    end
    answer = '0;
    if (part_setting == 0 || part_setting > held_count) begin
      answer.no_solution = 1'b1;
    end else begin
      lo = int'(held_max);
      hi = int'(held_total);
      while (lo <= hi) begin
        mid   = lo + (hi - lo) / 2;
        run   = 0;
        tally = 1;
        // Greedy pass: open a new part whenever the next element would overflow the limit.
        for (int i = 0; i < held_count; i++) begin
          if (run + int'(held_elements[i]) <= mid) begin
            run += int'(held_elements[i]);
          end else begin
            tally++;
            run = int'(held_elements[i]);
          end
        end
        if (tally > part_setting) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      answer.largest_sum = SUM_OUT_BITS'(lo);
    end
    expected_answers.push_back(answer);
    held_count = '0;
    held_max   = '0;
    held_total = '0;
  endfunction

  // Sender: offers the queued items one by one, keeping valid and data steady until
  // the block takes the item, and waits a drawn number of cycles before each new one.
  always @(posedge clk_i) begin : drive_items
    in_t  next_item;
    logic next_valid;
    next_item  = in_data_i;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        absorb_element(in_data_i);
        elements_sent++;
        next_valid = 1'b0;
        send_wait  = draw_wait();
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          next_item  = pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
    in_data_i  <= next_item;
  end

  // Receiver: checks each answer against the oldest prediction, then stalls for a
  // drawn number of cycles before it is ready for the next one.
  always @(posedge clk_i) begin : collect_answers
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          $error("answer with no prediction waiting: largest_sum %0d, no_solution %0d",
                 out_data_o.largest_sum, out_data_o.no_solution);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (out_data_o.largest_sum !== want.largest_sum) begin
            $error("largest_sum: expected %0d, actual %0d",
                   want.largest_sum, out_data_o.largest_sum);
            mismatches++;
          end
          if (out_data_o.no_solution !== want.no_solution) begin
            $error("no_solution: expected %0d, actual %0d",
                   want.no_solution, out_data_o.no_solution);
            mismatches++;
          end
          if (want.no_solution) begin
            no_solution_seen++;
          end
          answers_checked++;
        end
        recv_wait = draw_wait();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a search that never ends lands here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_element(input int value, input bit last);
    pending_items.push_back(in_t'{element_value: value[ELEMENT_BITS-1:0],
                                  last_element: last});
  endtask

  // Waits until every item has been taken and every answer checked. State is read on
  // the falling edge, when all updates of the rising edge have settled.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_items.size() != 0 || in_valid_i || expected_answers.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes part_count; only ever called while the block is idle.
  task automatic write_part_count(input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[PART_COUNT_BITS-1:0];
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    part_setting = value[PART_COUNT_BITS-1:0];
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int queued;
    int len;
    int style;
    int value;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Reset value of one part first: an all-zero single element gives a
    // search whose upper bound drops below zero, then the widest values as one part.
    push_element(0, 1'b1);
    push_element(65535, 1'b0);
    push_element(0, 1'b0);
    push_element(65535, 1'b1);
    wait_drained();

    // A part count of zero can never be met.
    write_part_count(0);
    push_element(7, 1'b1);
    push_element(3, 1'b0);
    push_element(5, 1'b1);
    wait_drained();

    // The largest count the register holds exceeds any sequence.
    write_part_count(2047);
    push_element(1, 1'b0);
    push_element(2, 1'b1);
    wait_drained();

    // Two parts: an even split, a sequence too short for two parts, and a real search.
    write_part_count(2);
    push_element(65535, 1'b0);
    push_element(65535, 1'b1);
    push_element(1, 1'b1);
    push_element(10, 1'b0);
    push_element(20, 1'b0);
    push_element(30, 1'b0);
    push_element(40, 1'b1);
    wait_drained();

    // Alternating bit patterns through the element field.
    write_part_count(3);
    push_element('h5555, 1'b0);
    push_element('hAAAA, 1'b0);
    push_element('hFFFF, 1'b0);
    push_element('h0001, 1'b1);
    wait_drained();

    // Random part: mostly short sequences with a spread of value styles, an occasional
    // longer one, and a new part count per round. Each round ends by draining the block,
    // so the sender also sits idle until every answer is back. Round two runs without
    // any idling on either side.
    queued = 0;
    for (int round = 0; round < 4; round++) begin
      idle_max = (round == 2) ? 0 : 6;
      write_part_count((round == 0) ? 2 : $urandom_range(1, 4 + 2 * round));
      while (queued < 62 * (round + 1)) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        style = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          case (style)
            0: begin
              value = $urandom_range(0, 65535);
            end
            1: begin
              value = $urandom_range(0, 15);
            end
            2: begin
              value = ($urandom_range(0, 1) == 0) ? 0 : 65535;
            end
            default: begin
              value = $urandom_range(0, 1) << $urandom_range(0, 15);
            end
          endcase
          push_element(value, k == len - 1);
          queued++;
        end
      end
      wait_drained();
    end
    idle_max = 6;

    // One part over a full store of the largest value gives the widest possible answer.
    // The three elements beyond the store's depth would raise the total if kept by
    // mistake, and the last flag comes on a dropped element and must still start the
    // search.
    write_part_count(1);
    for (int k = 0; k < MAX_ELEMENTS + 3; k++) begin
      push_element((k < MAX_ELEMENTS) ? 65535 : 1, k == MAX_ELEMENTS + 2);
    end
    wait_drained();

    $display("Run covered %0d elements and %0d answers (%0d without a solution),",
             elements_sent, answers_checked, no_solution_seen);
    $display("with part counts from zero to the register maximum and an overfull store.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
